[src/rgb3dlut_pkg.sv]
`timescale 1ns / 1ps
// shared types and constants for the rgb 3d lut color mapper
// no dependencies; imported by rgb_3d_lut_color_mapper_core
package rgb3dlut_pkg;

    localparam int GRID_POINTS_PER_AXIS = 16;
    localparam int FULL_SCALE           = 255;
    localparam int LUT_DEPTH            = GRID_POINTS_PER_AXIS * GRID_POINTS_PER_AXIS
                                          * GRID_POINTS_PER_AXIS;
    localparam int ADDR_W               = $clog2(LUT_DEPTH);
    localparam int IDX_W                = $clog2(GRID_POINTS_PER_AXIS);
    localparam int CNT_W                = $clog2(GRID_POINTS_PER_AXIS + 1);
    localparam int CC_W                 = $clog2(GRID_POINTS_PER_AXIS * GRID_POINTS_PER_AXIS + 1);
    localparam int CELL_W               = $clog2(LUT_DEPTH + 1);
    localparam int ENTRY_W              = 12;
    localparam int CMP_W                = (CELL_W > ENTRY_W) ? CELL_W : ENTRY_W;

    // smallest interval that keeps the grid within GRID_POINTS_PER_AXIS per axis
    localparam logic [7:0] MIN_INTERVAL   = 8'(FULL_SCALE / GRID_POINTS_PER_AXIS + 1);
    localparam logic [7:0] INTERVAL_RESET = 8'd16;
    localparam logic [7:0] EFF_IV_RESET   = (INTERVAL_RESET < MIN_INTERVAL) ? MIN_INTERVAL
                                                                            : INTERVAL_RESET;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_MAP  = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        logic [7:0]         in_red;
        logic [7:0]         in_green;
        logic [7:0]         in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
    } t_out_item;

endpackage

[src/rgb_3d_lut_color_mapper_core.sv]
`timescale 1ns / 1ps
// rgb 3d lut color mapper: pipelined grid-cell lookup into a 24-bit table
// depends on rgb3dlut_pkg for payload types and grid constants
//
// usage
//   input channel (i_valid / o_stall, payload i_in_data) carries two kinds of
//   transaction: a load inside the grid writes one rgb entry at entry_index,
//   a map looks up a pixel. only a map gives a result on the output channel
//   (o_valid / i_stall, payload o_out_data). results leave in input order.
//   config channel (i_cfg_valid / o_cfg_ready) writes grid_interval; it is
//   always ready and is to be written only with the pipeline empty.
// stages and throughput
//   one transaction per cycle while the output is not stalled. a map passes
//   through 4 divider stages (2 quotient bits per stage per channel),
//   2 address stages (address and grid-size multiplies), then the registered
//   table read. a load writes the table at the same point where a map reads it,
//   so a map right behind a load sees the new entry.
// reset
//   clears all stage valid bits and the output valid and sets the interval to
//   16. the table content is undefined until loaded.
// stall
//   a stalled result holds. bubbles in the pipe still close up behind it, so
//   input is taken until every stage is full; then o_stall rises.
module rgb_3d_lut_color_mapper_core
    import rgb3dlut_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    // input transactions
    input  logic      i_valid,
    output logic      o_stall,
    input  t_in_item  i_in_data,
    // results
    output logic      o_valid,
    input  logic      i_stall,
    output t_out_item o_out_data,
    // grid_interval write
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_data
);

    localparam int DIV_STAGES = 4;
    localparam int NUM_LANES  = 4;   // red, green, blue, and 255 for the grid count
    localparam int N_STAGES   = DIV_STAGES + 2;

    // one restoring-divider lane: quotient bits shift into num from the bottom
    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] num;
    } t_div_lane;

    typedef struct packed {
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        t_out_item          rgb;
        t_div_lane [NUM_LANES-1:0] lane;
    } t_div_stage;

    typedef struct packed {
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        t_out_item          rgb;
        logic [ADDR_W-1:0]  part_addr;   // ir*counts + ig
        logic [IDX_W-1:0]   ib;
        logic [CNT_W-1:0]   counts;
        logic [CC_W-1:0]    counts_sq;
    } t_addr1_stage;

    typedef struct packed {
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        t_out_item          rgb;
        logic [ADDR_W-1:0]  addr;
        logic               load_ok;
    } t_addr2_stage;

    function automatic t_div_lane div_step(input t_div_lane l, input logic [7:0] iv);
        logic [8:0] t;
        t_div_lane  o;
        t     = {l.rem, l.num[7]};
        o.num = {l.num[6:0], 1'b0};
        if (t >= {1'b0, iv}) begin
            t        = t - {1'b0, iv};
            o.num[0] = 1'b1;
        end
        o.rem = t[7:0];
        return o;
    endfunction

    // control
    logic [7:0]          r_eff_iv;
    logic [N_STAGES-1:0] r_vld;
    logic                r_out_valid;
    logic [N_STAGES:0]   stage_rdy;

    // payload
    t_div_stage   r_div [DIV_STAGES];
    t_div_stage   n_div [DIV_STAGES];
    t_addr1_stage r_a1, n_a1;
    t_addr2_stage r_a2, n_a2;
    t_out_item    r_rd_data;

    t_out_item    r_lut [LUT_DEPTH];

    // handshake: a stage takes new data when it is empty or its successor moves
    always_comb begin
        stage_rdy[N_STAGES] = !r_out_valid || !i_stall;
        for (int k = N_STAGES - 1; k >= 0; k--) begin
            stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    end

    assign o_stall     = !stage_rdy[0];
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_out_data  = r_rd_data;

    // divider stages, two quotient bits each
    always_comb begin
        t_div_stage src;
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (k == 0) begin
                src.req_type     = i_in_data.req_type;
                src.entry_index  = i_in_data.entry_index;
                src.rgb.out_red   = i_in_data.in_red;
                src.rgb.out_green = i_in_data.in_green;
                src.rgb.out_blue  = i_in_data.in_blue;
                src.lane[0] = '{rem: 8'd0, num: i_in_data.in_red};
                src.lane[1] = '{rem: 8'd0, num: i_in_data.in_green};
                src.lane[2] = '{rem: 8'd0, num: i_in_data.in_blue};
                src.lane[3] = '{rem: 8'd0, num: 8'(FULL_SCALE)};
            end else begin
                src = r_div[k-1];
            end
            n_div[k] = src;
            for (int l = 0; l < NUM_LANES; l++) begin
                n_div[k].lane[l] = div_step(div_step(src.lane[l], r_eff_iv), r_eff_iv);
            end
        end
    end

    // first address stage: ir*counts + ig, counts^2
    always_comb begin
        logic [CNT_W-1:0] counts;
        counts = CNT_W'(r_div[DIV_STAGES-1].lane[3].num) + CNT_W'(1);
        n_a1.req_type    = r_div[DIV_STAGES-1].req_type;
        n_a1.entry_index = r_div[DIV_STAGES-1].entry_index;
        n_a1.rgb         = r_div[DIV_STAGES-1].rgb;
        n_a1.counts      = counts;
        n_a1.ib          = IDX_W'(r_div[DIV_STAGES-1].lane[2].num);
        n_a1.part_addr   = ADDR_W'(ADDR_W'(IDX_W'(r_div[DIV_STAGES-1].lane[0].num))
                                   * ADDR_W'(counts)
                                   + ADDR_W'(IDX_W'(r_div[DIV_STAGES-1].lane[1].num)));
        n_a1.counts_sq   = CC_W'(CC_W'(counts) * CC_W'(counts));
    end

    // second address stage: flat address and load range check against counts^3
    always_comb begin
        logic [CELL_W-1:0] cells;
        cells = CELL_W'(CELL_W'(r_a1.counts_sq) * CELL_W'(r_a1.counts));
        n_a2.req_type    = r_a1.req_type;
        n_a2.entry_index = r_a1.entry_index;
        n_a2.rgb         = r_a1.rgb;
        n_a2.addr        = ADDR_W'(r_a1.part_addr * ADDR_W'(r_a1.counts)
                                   + ADDR_W'(r_a1.ib));
        n_a2.load_ok     = CMP_W'(r_a1.entry_index) < CMP_W'(cells);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff_iv    <= EFF_IV_RESET;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                // intervals below the minimum are raised to it
                r_eff_iv <= (i_cfg_data < MIN_INTERVAL) ? MIN_INTERVAL : i_cfg_data;
            end
            if (stage_rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k < N_STAGES; k++) begin
                if (stage_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (stage_rdy[N_STAGES]) begin
                r_out_valid <= r_vld[N_STAGES-1] && (r_a2.req_type == REQ_MAP);
            end
        end
    end

    // stage payload, no reset
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STAGES; k++) begin
            if (stage_rdy[k]) begin
                r_div[k] <= n_div[k];
            end
        end
        if (stage_rdy[DIV_STAGES]) begin
            r_a1 <= n_a1;
        end
        if (stage_rdy[DIV_STAGES+1]) begin
            r_a2 <= n_a2;
        end
    end

    // table: single port, one load write or one map read per cycle
    always_ff @(posedge i_clk) begin
        if (stage_rdy[N_STAGES] && r_vld[N_STAGES-1]) begin
            if (r_a2.req_type == REQ_MAP) begin
                r_rd_data <= r_lut[r_a2.addr];
            end else if (r_a2.load_ok) begin
                r_lut[ADDR_W'(r_a2.entry_index)] <= r_a2.rgb;
            end
        end
    end

endmodule

[tb/sv/tb_rgb_3d_lut_color_mapper_core.sv]
`timescale 1ns / 1ps
// self-checking testbench for rgb_3d_lut_color_mapper_core: table loads and pixel lookups
// depends on rgb3dlut_pkg for payload types and grid constants, and on the core itself
module tb_rgb_3d_lut_color_mapper_core;
    import rgb3dlut_pkg::*;

    localparam int WAIT_MAX        = 17;
    localparam int PIPE_SETTLE     = 12;
    localparam int ITEMS_PER_PHASE = 100;
    localparam int DRAIN_LIMIT     = 4000;

    typedef enum logic {ROW_CFG, ROW_ITEM} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic [7:0] interval;
        t_in_item   item;
        bit         has_color;
        t_out_item  color;
    } t_dir_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_in_item   i_in_data;
    logic       o_valid;
    logic       i_stall;
    t_out_item  o_out_data;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_data;

    // shadow of the table and of the interval register
    t_out_item   lut_shadow [LUT_DEPTH];
    bit          lut_loaded [LUT_DEPTH];
    logic [7:0]  grid_iv_shadow;

    t_out_item   mapped_color_q [$];
    int unsigned readable_cells [$];
    t_dir_row    directed_rows [$];

    bit no_idle;
    int error_count;
    int results_seen;
    int loads_sent;
    int loads_dropped;
    int maps_sent;

    rgb_3d_lut_color_mapper_core u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_in_data   (i_in_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // intervals below the minimum are raised to it
    function automatic int unsigned eff_interval();
        return (grid_iv_shadow < MIN_INTERVAL) ? int'(MIN_INTERVAL) : int'(grid_iv_shadow);
    endfunction

    function automatic int unsigned grid_counts();
        return FULL_SCALE / eff_interval() + 1;
    endfunction

    function automatic int unsigned grid_cells();
        int unsigned n;
        n = grid_counts();
        return n * n * n;
    endfunction

    // applies one transaction to the shadow table; returns 1 when it yields a color
    function automatic bit predict_lookup(input t_in_item it, output t_out_item color);
        int unsigned iv;
        int unsigned n;
        int unsigned addr;
        iv    = eff_interval();
        n     = grid_counts();
        color = '0;
        if (it.req_type == REQ_LOAD) begin
            if (it.entry_index < grid_cells()) begin
                lut_shadow[it.entry_index] = {it.in_red, it.in_green, it.in_blue};
                lut_loaded[it.entry_index] = 1'b1;
            end
            return 1'b0;
        end
        addr = ((it.in_red / iv) * n + it.in_green / iv) * n + it.in_blue / iv;
        if (lut_loaded[addr]) begin
            color = lut_shadow[addr];
        end
        return 1'b1;
    endfunction

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, WAIT_MAX);
    endfunction

    function automatic void add_cfg(input logic [7:0] value);
        t_dir_row row;
        row.kind      = ROW_CFG;
        row.interval  = value;
        row.item      = '0;
        row.has_color = 1'b0;
        row.color     = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_load(input logic [11:0] idx, input logic [23:0] rgb);
        t_dir_row row;
        row.kind      = ROW_ITEM;
        row.interval  = '0;
        row.item      = {REQ_LOAD, idx, rgb};
        row.has_color = 1'b0;
        row.color     = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_map(input logic [23:0] pixel, input bit has_color,
                                    input logic [23:0] color);
        t_dir_row row;
        row.kind      = ROW_ITEM;
        row.interval  = '0;
        row.item      = {REQ_MAP, 12'($urandom), pixel};
        row.has_color = has_color;
        row.color     = color;
        directed_rows.push_back(row);
    endfunction

    // a pixel anywhere inside the given grid point under the current geometry
    function automatic t_in_item pixel_for_cell(input int unsigned addr);
        int unsigned iv;
        int unsigned n;
        int unsigned grid_pos [3];
        int unsigned base;
        int unsigned span;
        logic [7:0]  pix [3];
        t_in_item    it;
        iv          = eff_interval();
        n           = grid_counts();
        grid_pos[0] = addr / (n * n);
        grid_pos[1] = (addr / n) % n;
        grid_pos[2] = addr % n;
        for (int k = 0; k < 3; k++) begin
            base   = grid_pos[k] * iv;
            span   = (FULL_SCALE - base < iv - 1) ? FULL_SCALE - base : iv - 1;
            pix[k] = 8'(base + $urandom_range(0, span));
        end
        it.req_type    = REQ_MAP;
        it.entry_index = 12'($urandom);
        it.in_red      = pix[0];
        it.in_green    = pix[1];
        it.in_blue     = pix[2];
        return it;
    endfunction

    // mostly lookups into loaded cells, loads inside the grid, a few loads anywhere
    function automatic t_in_item random_request();
        int unsigned roll;
        t_in_item    it;
        roll = $urandom_range(0, 99);
        if (roll >= 40 && readable_cells.size() != 0) begin
            return pixel_for_cell(readable_cells[$urandom_range(0, readable_cells.size() - 1)]);
        end
        it.req_type    = REQ_LOAD;
        it.entry_index = (roll < 5) ? 12'($urandom) : 12'($urandom_range(0, grid_cells() - 1));
        it.in_red      = 8'($urandom);
        it.in_green    = 8'($urandom);
        it.in_blue     = 8'($urandom);
        return it;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (got !== want) begin
            $display("%0t mismatch %s: expected %02h, actual %02h", $time, name, want, got);
            error_count++;
        end
    endfunction

    function automatic void check_color(input t_out_item got);
        t_out_item want;
        if (mapped_color_q.size() == 0) begin
            $display("%0t unexpected result: expected none, actual %06h", $time, got);
            error_count++;
            return;
        end
        want = mapped_color_q.pop_front();
        results_seen++;
        compare_field("out_red", want.out_red, got.out_red);
        compare_field("out_green", want.out_green, got.out_green);
        compare_field("out_blue", want.out_blue, got.out_blue);
    endfunction

    // one input transaction; entered right after the previous acceptance edge
    task automatic send_request(input t_in_item it, input bit has_want, input t_out_item want);
        int        gap;
        bit        in_grid;
        bit        fresh;
        t_out_item color;
        gap = draw_wait();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_data <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        in_grid = it.entry_index < grid_cells();
        fresh   = !lut_loaded[it.entry_index];
        if (predict_lookup(it, color)) begin
            mapped_color_q.push_back(has_want ? want : color);
            maps_sent++;
        end else if (in_grid) begin
            loads_sent++;
            if (fresh) begin
                readable_cells.push_back(it.entry_index);
            end
        end else begin
            loads_dropped++;
        end
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // interval writes happen only with the pipe empty
    task automatic write_interval(input logic [7:0] value);
        release_input();
        while (mapped_color_q.size() != 0) @(posedge i_clk);
        // a trailing load gives no result, so let it clear the pipe
        repeat (PIPE_SETTLE) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        grid_iv_shadow = value;
        readable_cells.delete();
        for (int unsigned a = 0; a < grid_cells(); a++) begin
            if (lut_loaded[a]) begin
                readable_cells.push_back(a);
            end
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // result sink with random back-pressure
    initial begin
        int gap;
        i_stall = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = draw_wait();
            @(negedge i_clk);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            check_color(o_out_data);
        end
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d results outstanding", mapped_color_q.size());
        $display("FAIL rgb_3d_lut_color_mapper_core");
        $finish;
    end

    initial begin
        t_out_item   no_color;
        int unsigned phase_iv [$];
        int          counted;
        t_in_item    it;
        bit          counts_toward;
        int          waited;

        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_in_data      = '0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        no_idle        = 1'b0;
        grid_iv_shadow = INTERVAL_RESET;
        error_count    = 0;
        results_seen   = 0;
        loads_sent     = 0;
        loads_dropped  = 0;
        maps_sent      = 0;
        no_color       = '0;

        // directed part at the reset interval: extremes, a lookup right behind its load
        add_load(12'd0, 24'hFFFFFF);
        add_load(12'd4095, 24'h000000);
        add_map(24'h000000, 1'b1, 24'hFFFFFF);
        add_map(24'hFFFFFF, 1'b1, 24'h000000);
        add_load(12'h555, 24'hA55AC3);
        add_map(24'h5F5055, 1'b0, 24'h0);
        add_load(12'd0, 24'h123456);
        add_map(24'h0F0F0F, 1'b0, 24'h0);
        add_load(12'd8, 24'h0FF03C);
        add_map(24'h000080, 1'b0, 24'h0);
        add_load(12'd7, 24'h778899);
        add_map(24'h00007F, 1'b0, 24'h0);
        // widest interval: 2x2x2 grid, loads past the grid are dropped
        add_cfg(8'd255);
        add_load(12'd8, 24'hDEAD00);
        add_load(12'd4095, 24'hABCDEF);
        add_map(24'hFFFFFF, 1'b0, 24'h0);
        add_map(24'hFE0000, 1'b0, 24'h0);
        add_load(12'd4, 24'h445566);
        add_map(24'hFF00FE, 1'b0, 24'h0);
        // zero interval is raised to the minimum; table survives the change
        add_cfg(8'd0);
        add_map(24'h000080, 1'b0, 24'h0);
        add_map(24'hFFFFFF, 1'b1, 24'h000000);
        add_map(24'h000040, 1'b0, 24'h0);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_interval(directed_rows[i].interval);
            end else begin
                send_request(directed_rows[i].item, directed_rows[i].has_color,
                             directed_rows[i].color);
            end
        end

        // random phases, one per interval setting; every third phase runs without idling
        phase_iv = '{16, 255, 15, 17, 85, 128, 51, 200, 31, 64};
        phase_iv.push_back($urandom_range(0, 255));
        phase_iv.push_back($urandom_range(16, 255));
        foreach (phase_iv[p]) begin
            write_interval(8'(phase_iv[p]));
            no_idle = (p % 3 == 1);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it            = random_request();
                counts_toward = it.req_type == REQ_MAP || it.entry_index < grid_cells();
                send_request(it, 1'b0, no_color);
                if (counts_toward) begin
                    counted++;
                end
            end
        end
        no_idle = 1'b0;
        release_input();

        waited = 0;
        while (mapped_color_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (PIPE_SETTLE) @(posedge i_clk);
        if (mapped_color_q.size() != 0) begin
            $display("%0t missing results: expected %0d more, actual none",
                     $time, mapped_color_q.size());
            error_count++;
        end

        $display("ran %0d table writes, %0d dropped out-of-grid writes, %0d lookups",
                 loads_sent, loads_dropped, maps_sent);
        $display("over %0d interval settings; %0d colors compared, %0d mismatches",
                 phase_iv.size() + 2, results_seen, error_count);
        if (error_count == 0) begin
            $display("PASS rgb_3d_lut_color_mapper_core");
        end else begin
            $display("FAIL rgb_3d_lut_color_mapper_core");
        end
        $finish;
    end

endmodule

[sim.f]
src/rgb3dlut_pkg.sv
src/rgb_3d_lut_color_mapper_core.sv
tb/sv/tb_rgb_3d_lut_color_mapper_core.sv
